FILE: rtl/core/htk_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the hashed key table
// no dependencies
package htk_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_MISSING  = 3'd3,
    ST_TOO_LONG = 3'd4
  } htk_status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } htk_op_e;

  // control part of a job handed from front to back
  typedef struct packed {
    logic op;
    logic too_long;
  } htk_ctl_t;

  localparam logic [31:0] MixC1   = 32'hcc9e2d51;
  localparam logic [31:0] MixC2   = 32'h1b873593;
  localparam logic [31:0] MixAdd  = 32'he6546b64;
  localparam logic [31:0] FinC1   = 32'h85ebca6b;
  localparam logic [31:0] FinC2   = 32'hc2b2ae35;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

FILE: rtl/core/htk_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module htk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/htk_queue.sv
`timescale 1ns / 1ps
// two entry job queue between hashing front and probing back
// no dependencies
module htk_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/htk_front.sv
`timescale 1ns / 1ps
// front end: takes key chunks, runs the murmur style hash, reduces it to a home slot
// depends on htk_pkg
module htk_front import htk_pkg::*; #(
  parameter int SLOT_COUNT    = 256,
  parameter int KEY_BYTES_MAX = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    busy_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    op_i,
  input  logic [31:0]                             key_chunk_i,
  input  logic [2:0]                              chunk_bytes_i,
  input  logic                                    chunk_last_i,
  input  logic [31:0]                             entry_value_i,
  output logic                                    job_valid_o,
  input  logic                                    job_full_i,
  output htk_ctl_t                                job_ctl_o,
  output logic [$clog2(SLOT_COUNT)-1:0]           job_slot_o,
  output logic [((KEY_BYTES_MAX+3)/4)*32-1:0]     job_words_o,
  output logic [$clog2(KEY_BYTES_MAX+1)-1:0]      job_len_o,
  output logic [31:0]                             job_value_o
);

  localparam int  SW       = $clog2(SLOT_COUNT);
  localparam int  LW       = $clog2(KEY_BYTES_MAX + 1);
  localparam int  KW       = (KEY_BYTES_MAX + 3) / 4;
  localparam bit  SlotPow2 = ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0);
  // rounded-up reciprocal, exact quotient for every 32-bit hash
  localparam int          RecipShift = 32 + SW;
  localparam logic [32:0] Recip      = 33'(((65'd1 << RecipShift) + 65'(SLOT_COUNT)
                                            - 65'd1) / 65'(SLOT_COUNT));

  typedef enum logic [3:0] {
    F_IDLE, F_M1, F_M2, F_MIX, F_FIN, F_F2, F_F3, F_MOD, F_RED, F_PUSH
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [31:0]        h_q, h_d;
  logic [31:0]        m_q, m_d;
  logic [31:0]        chunk_q, chunk_d;
  logic [LW-1:0]      len_q, len_d;
  logic [KW*32-1:0]   words_q, words_d;
  logic               tail_q, tail_d;
  logic               last_q, last_d;
  logic               op_q, op_d;
  logic [31:0]        val_q, val_d;
  logic               toolong_q, toolong_d;
  logic [64:0]        prod_q, prod_d;
  logic [SW-1:0]      slot_q, slot_d;

  logic               accept;
  logic [2:0]         nb;
  logic [31:0]        chunk_m;
  logic [LW:0]        len_sum;
  logic [LW-1:0]      len_new;
  logic [LW-1:0]      widx;
  logic [31:0]        x0, x1, fin;
  logic [31:0]        quot, remw;

  assign in_stall_o  = (state_q != F_IDLE) || busy_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign job_valid_o = (state_q == F_PUSH);
  assign job_ctl_o   = '{op: op_q, too_long: toolong_q};
  assign job_slot_o  = slot_q;
  assign job_words_o = words_q;
  assign job_len_o   = len_q;
  assign job_value_o = val_q;

  always_comb begin
    nb = (!chunk_last_i || chunk_bytes_i > 3'd4) ? 3'd4 : chunk_bytes_i;
    case (nb)
      3'd0:    chunk_m = 32'd0;
      3'd1:    chunk_m = {24'd0, key_chunk_i[7:0]};
      3'd2:    chunk_m = {16'd0, key_chunk_i[15:0]};
      3'd3:    chunk_m = {8'd0, key_chunk_i[23:0]};
      default: chunk_m = key_chunk_i;
    endcase
    len_sum = {1'b0, len_q} + (LW+1)'(nb);
    len_new = (len_sum > (LW+1)'(KEY_BYTES_MAX)) ? LW'(KEY_BYTES_MAX) : len_sum[LW-1:0];
    widx    = len_q >> 2;
    // finaliser pieces
    x0  = h_q ^ 32'(len_q);
    x0  = x0 ^ (x0 >> 16);
    x1  = m_q ^ (m_q >> 13);
    fin = m_q ^ (m_q >> 16);
    // remainder from the registered reciprocal product
    quot = 32'(prod_q >> RecipShift);
    remw = h_q - quot * 32'(SLOT_COUNT);
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    m_d       = m_q;
    chunk_d   = chunk_q;
    len_d     = len_q;
    words_d   = words_q;
    tail_d    = tail_q;
    last_d    = last_q;
    op_d      = op_q;
    val_d     = val_q;
    toolong_d = toolong_q;
    prod_d    = prod_q;
    slot_d    = slot_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          for (int i = 0; i < KW; i++) begin
            if (widx == LW'(i)) begin
              words_d[i*32 +: 32] = chunk_m;
            end
          end
          chunk_d   = chunk_m;
          len_d     = len_new;
          tail_d    = (nb != 3'd4);
          last_d    = chunk_last_i;
          op_d      = op_i;
          val_d     = entry_value_i;
          toolong_d = 1'b0;
          if (chunk_last_i && len_new >= LW'(KEY_BYTES_MAX)) begin
            toolong_d = 1'b1;
            state_d   = F_PUSH;
          end else if (nb == 3'd0) begin
            state_d = F_FIN;
          end else begin
            state_d = F_M1;
          end
        end
      end
      F_M1: begin
        m_d     = chunk_q * MixC1;
        state_d = F_M2;
      end
      F_M2: begin
        m_d     = rotl32(m_q, 15) * MixC2;
        state_d = F_MIX;
      end
      F_MIX: begin
        if (tail_q) begin
          h_d = h_q ^ m_q;
        end else begin
          h_d = rotl32(h_q ^ m_q, 13) * 32'd5 + MixAdd;
        end
        state_d = last_q ? F_FIN : F_IDLE;
      end
      F_FIN: begin
        m_d     = x0 * FinC1;
        state_d = F_F2;
      end
      F_F2: begin
        m_d     = x1 * FinC2;
        state_d = F_F3;
      end
      F_F3: begin
        h_d = fin;
        if (SlotPow2) begin
          slot_d  = fin[SW-1:0];
          state_d = F_PUSH;
        end else begin
          state_d = F_MOD;
        end
      end
      F_MOD: begin
        prod_d  = 65'(h_q) * 65'(Recip);
        state_d = F_RED;
      end
      F_RED: begin
        slot_d  = remw[SW-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!job_full_i) begin
          words_d = '0;
          h_d     = '0;
          len_d   = '0;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      h_q     <= '0;
      len_q   <= '0;
      words_q <= '0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      len_q   <= len_d;
      words_q <= words_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    chunk_q   <= chunk_d;
    tail_q    <= tail_d;
    last_q    <= last_d;
    op_q      <= op_d;
    val_q     <= val_d;
    toolong_q <= toolong_d;
    prod_q    <= prod_d;
    slot_q    <= slot_d;
  end

endmodule

FILE: rtl/core/htk_back.sv
`timescale 1ns / 1ps
// back end: clears the table after reset, then probes slots linearly per job
// depends on htk_pkg and htk_ram
module htk_back import htk_pkg::*; #(
  parameter int SLOT_COUNT    = 256,
  parameter int KEY_BYTES_MAX = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                busy_o,
  input  logic                                job_empty_i,
  output logic                                job_pop_o,
  input  htk_ctl_t                            job_ctl_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]       job_slot_i,
  input  logic [((KEY_BYTES_MAX+3)/4)*32-1:0] job_words_i,
  input  logic [$clog2(KEY_BYTES_MAX+1)-1:0]  job_len_i,
  input  logic [31:0]                         job_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [31:0]                         found_value_o
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(KEY_BYTES_MAX + 1);
  localparam int KW = (KEY_BYTES_MAX + 3) / 4;
  localparam int EW = KW * 32 + LW + 32;

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_RD, B_CHK} back_state_e;

  back_state_e      state_q;
  logic [SW-1:0]    cnt_q;
  logic [SW-1:0]    s_q;
  logic             op_q;
  logic [KW*32-1:0] words_q;
  logic [LW-1:0]    len_q;
  logic [31:0]      val_q;
  logic             ov_q;
  htk_status_e      status_q;
  logic [31:0]      found_q;

  logic             out_free;
  logic             ov_set;
  logic             used_rd;
  logic [EW-1:0]    entry_rd;
  logic             hit;
  logic             empty_slot;
  logic             sweep_done;
  logic             key_we, used_we;
  logic [SW-1:0]    used_waddr;
  logic             used_wdata;

  assign out_free   = !ov_q || !out_stall_i;
  assign busy_o     = (state_q == B_CLR);
  assign empty_slot = !used_rd;
  assign hit        = used_rd && (entry_rd[EW-1 -: KW*32] == words_q)
                      && (entry_rd[31+LW -: LW] == len_q);
  assign sweep_done = (cnt_q == SW'(SLOT_COUNT - 1));
  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i
                      && (!job_ctl_i.too_long || out_free);
  // a result is loaded for a too-long job or at the end of a probe
  assign ov_set     = (job_pop_o && job_ctl_i.too_long)
                      || ((state_q == B_CHK) && (empty_slot || hit || sweep_done) && out_free);

  always_comb begin
    key_we     = (state_q == B_CHK) && out_free && empty_slot && (op_q == OP_INSERT);
    used_we    = key_we || (state_q == B_CLR);
    used_waddr = (state_q == B_CLR) ? cnt_q : s_q;
    used_wdata = (state_q != B_CLR);
  end

  htk_ram #(.WIDTH(EW), .DEPTH(SLOT_COUNT)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (s_q),
    .wdata_i ({words_q, len_q, val_q}),
    .raddr_i (s_q),
    .rdata_o (entry_rd)
  );

  htk_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (s_q),
    .rdata_o (used_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_CLR;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
      s_q      <= '0;
      status_q <= ST_OK;
      found_q  <= '0;
    end else begin
      ov_q <= ov_set || (ov_q && out_stall_i);
      case (state_q)
        B_CLR: begin
          cnt_q <= cnt_q + SW'(1);
          if (sweep_done) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_pop_o) begin
            s_q   <= job_slot_i;
            cnt_q <= '0;
            if (job_ctl_i.too_long) begin
              status_q <= ST_TOO_LONG;
              found_q  <= '0;
            end else begin
              state_q <= B_RD;
            end
          end
        end
        B_RD: state_q <= B_CHK;
        B_CHK: begin
          if (empty_slot || hit || sweep_done) begin
            if (out_free) begin
              found_q <= '0;
              state_q <= B_IDLE;
              if (empty_slot) begin
                status_q <= (op_q == OP_INSERT) ? ST_OK : ST_MISSING;
              end else if (hit) begin
                if (op_q == OP_INSERT) begin
                  status_q <= ST_DUP;
                end else begin
                  status_q <= ST_OK;
                  found_q  <= entry_rd[31:0];
                end
              end else begin
                status_q <= (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
              end
            end
          end else begin
            s_q     <= (s_q == SW'(SLOT_COUNT - 1)) ? '0 : s_q + SW'(1);
            cnt_q   <= cnt_q + SW'(1);
            state_q <= B_RD;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      op_q    <= job_ctl_i.op;
      words_q <= job_words_i;
      len_q   <= job_len_i;
      val_q   <= job_value_i;
    end
  end

  assign out_valid_o   = ov_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

endmodule

FILE: rtl/core/hashed_key_table_unit.sv
`timescale 1ns / 1ps
// hashed key table: key to value map with murmur hash and linear probing
// depends on htk_pkg, htk_front, htk_queue, htk_back
//
// usage:
//   input channel (in_valid_i / in_stall_o) carries one key chunk per transaction,
//   little-endian bytes, chunk_last_i on the final one; op_i and entry_value_i
//   are taken from the last chunk. output channel (out_valid_o / out_stall_i)
//   carries one status/found_value transaction per last chunk, none otherwise.
// hashing: each chunk takes two registered multiplies per scramble, then a mix;
//   a last chunk adds the finaliser and a hand-off, plus a reciprocal remainder
//   when SLOT_COUNT is not a power of two; the front takes a new chunk only when idle.
// probing: after taking a job, the probe unit visits each slot with a registered
//   ram read then a compare, at most SLOT_COUNT slots.
// a two-entry queue sits between hashing and probing so the next key can hash
//   while the previous one probes.
// reset: the slot-used memory is swept clear, slot by slot, during which
//   in_stall_o is high. a stalled result holds in the output register; the
//   probe unit waits on it, the queue fills and then the input stalls.
module hashed_key_table_unit import htk_pkg::*; #(
  parameter int SLOT_COUNT    = 256,
  parameter int KEY_BYTES_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] key_chunk_i,
  input  logic [2:0]  chunk_bytes_i,
  input  logic        chunk_last_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(KEY_BYTES_MAX + 1);
  localparam int KW = (KEY_BYTES_MAX + 3) / 4;
  localparam int QW = $bits(htk_ctl_t) + SW + KW * 32 + LW + 32;

  logic             busy;
  logic             f_valid, q_full, q_empty, q_pop;
  htk_ctl_t         f_ctl, b_ctl;
  logic [SW-1:0]    f_slot, b_slot;
  logic [KW*32-1:0] f_words, b_words;
  logic [LW-1:0]    f_len, b_len;
  logic [31:0]      f_val, b_val;
  logic [QW-1:0]    q_in, q_out;

  htk_front #(.SLOT_COUNT(SLOT_COUNT), .KEY_BYTES_MAX(KEY_BYTES_MAX)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .busy_i        (busy),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .key_chunk_i   (key_chunk_i),
    .chunk_bytes_i (chunk_bytes_i),
    .chunk_last_i  (chunk_last_i),
    .entry_value_i (entry_value_i),
    .job_valid_o   (f_valid),
    .job_full_i    (q_full),
    .job_ctl_o     (f_ctl),
    .job_slot_o    (f_slot),
    .job_words_o   (f_words),
    .job_len_o     (f_len),
    .job_value_o   (f_val)
  );

  assign q_in = {f_ctl, f_slot, f_words, f_len, f_val};
  assign {b_ctl, b_slot, b_words, b_len, b_val} = q_out;

  htk_queue #(.WIDTH(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  htk_back #(.SLOT_COUNT(SLOT_COUNT), .KEY_BYTES_MAX(KEY_BYTES_MAX)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .busy_o        (busy),
    .job_empty_i   (q_empty),
    .job_pop_o     (q_pop),
    .job_ctl_i     (b_ctl),
    .job_slot_i    (b_slot),
    .job_words_i   (b_words),
    .job_len_i     (b_len),
    .job_value_i   (b_val),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

endmodule

FILE: rtl/core/htk_checker.sv
`timescale 1ns / 1ps
// port level checks for the hashed key table, bound to the top level
// depends on htk_pkg and hashed_key_table_unit
module htk_checker import htk_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] found_value_o
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a value is only reported for a successful lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (found_value_o == 32'd0))
    else $error("found value set on failing status");

  // every chunk keeps the hash front busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took chunks on consecutive cycles");

endmodule

bind hashed_key_table_unit htk_checker u_htk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .found_value_o (found_value_o)
);
